// ===== rtl/core/lav_pkg.sv =====
// Shared types and pipeline depths for the look-at view rotation block.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none
package lav_pkg;

    typedef logic signed [31:0] t_s32;
    typedef logic signed [63:0] t_s64;
    typedef t_s32 [2:0] t_vec32;
    typedef t_s64 [2:0] t_vec64;

    // one root bit per square-root stage, one quotient bit per divide stage
    localparam int SQRT_STEPS = 31;
    localparam int DIV_STEPS  = 31;
    localparam int DIV_LAT    = DIV_STEPS + 1;
    localparam int NORM_LAT   = 6 + SQRT_STEPS + DIV_LAT + 1;
    localparam int CROSS_LAT  = 2;
    localparam int TOTAL_LAT  = 2 + 3 * NORM_LAT + 2 * CROSS_LAT;

endpackage
`default_nettype wire

// ===== rtl/core/look_at_view_rotation.sv =====
// Look-at view rotation: three normalized rows side, upright and back in Q1.16.
// One word per cycle enters at start and leaves at o_valid.
// Each of the three normalizers is built on a 31-stage square root and a 31-stage
// divider; the two cross products sit between the normalizers.
// busy stays low and the result strobe cannot be held off.
// Synchronous active-low reset clears every valid bit; payload is not reset.
`default_nettype none
module look_at_view_rotation
    import lav_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] i_eye_x,
    input  wire logic [31:0] i_eye_y,
    input  wire logic [31:0] i_eye_z,
    input  wire logic [31:0] i_target_x,
    input  wire logic [31:0] i_target_y,
    input  wire logic [31:0] i_target_z,
    input  wire logic [31:0] i_up_x,
    input  wire logic [31:0] i_up_y,
    input  wire logic [31:0] i_up_z,
    output logic             o_valid,
    output logic [17:0]      o_side_x,
    output logic [17:0]      o_side_y,
    output logic [17:0]      o_side_z,
    output logic [17:0]      o_upright_x,
    output logic [17:0]      o_upright_y,
    output logic [17:0]      o_upright_z,
    output logic [17:0]      o_back_x,
    output logic [17:0]      o_back_y,
    output logic [17:0]      o_back_z
);

    localparam int ZX_LEN = NORM_LAT + CROSS_LAT;

    function automatic logic [17:0] to_q16(input t_s32 c);
        logic [30:0] m;
        logic [16:0] rnd;
        m   = c[31] ? 31'(-c) : c[30:0];
        rnd = 17'((32'(m) + 32'd8192) >> 14);
        return c[31] ? 18'(-$signed({1'b0, rnd})) : {1'b0, rnd};
    endfunction

    t_vec32 eye, target, up;
    t_vec64 r_z0;
    t_vec32 r_up0;
    logic   r_v0;
    t_vec32 r_ud [NORM_LAT];
    t_vec32 r_zd [2 * ZX_LEN];
    t_vec32 r_xd [ZX_LEN];

    logic   zn_valid, cx_valid, xn_valid, cy_valid, yn_valid;
    t_vec32 zq, xq, yq;
    t_vec64 xv, yv;

    logic        r_out_valid;
    logic [17:0] r_side [3];
    logic [17:0] r_upr  [3];
    logic [17:0] r_back [3];

    assign busy   = 1'b0;
    assign eye    = {i_eye_z, i_eye_y, i_eye_x};
    assign target = {i_target_z, i_target_y, i_target_x};
    assign up     = {i_up_z, i_up_y, i_up_x};

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_z0[i] <= 64'($signed(eye[i])) - 64'($signed(target[i]));
        end
        r_up0   <= up;
        r_ud[0] <= r_up0;
        r_zd[0] <= zq;
        r_xd[0] <= xq;
        for (int k = 1; k < NORM_LAT; k++) r_ud[k] <= r_ud[k-1];
        for (int k = 1; k < 2 * ZX_LEN; k++) r_zd[k] <= r_zd[k-1];
        for (int k = 1; k < ZX_LEN; k++) r_xd[k] <= r_xd[k-1];
        for (int i = 0; i < 3; i++) begin
            r_side[i] <= to_q16(r_xd[ZX_LEN-1][i]);
            r_upr[i]  <= to_q16(yq[i]);
            r_back[i] <= to_q16(r_zd[2*ZX_LEN-1][i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v0        <= start && !busy;
            r_out_valid <= yn_valid;
        end
    end

    lav_norm u_norm_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v0),
        .i_vec   (r_z0),
        .o_valid (zn_valid),
        .o_vec   (zq)
    );

    lav_cross u_cross_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (zn_valid),
        .i_a     (r_ud[NORM_LAT-1]),
        .i_b     (zq),
        .o_valid (cx_valid),
        .o_c     (xv)
    );

    lav_norm u_norm_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cx_valid),
        .i_vec   (xv),
        .o_valid (xn_valid),
        .o_vec   (xq)
    );

    lav_cross u_cross_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (xn_valid),
        .i_a     (r_zd[ZX_LEN-1]),
        .i_b     (xq),
        .o_valid (cy_valid),
        .o_c     (yv)
    );

    lav_norm u_norm_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cy_valid),
        .i_vec   (yv),
        .o_valid (yn_valid),
        .o_vec   (yq)
    );

    assign o_valid     = r_out_valid;
    assign o_side_x    = r_side[0];
    assign o_side_y    = r_side[1];
    assign o_side_z    = r_side[2];
    assign o_upright_x = r_upr[0];
    assign o_upright_y = r_upr[1];
    assign o_upright_z = r_upr[2];
    assign o_back_x    = r_back[0];
    assign o_back_y    = r_back[1];
    assign o_back_z    = r_back[2];

`ifndef SYNTHESIS
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##TOTAL_LAT o_valid)
        else $error("accepted word did not come out after the pipeline depth");

    a_unit_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($signed(o_side_x) <= 18'sd65536 && $signed(o_side_x) >= -18'sd65536
                  && $signed(o_back_x) <= 18'sd65536 && $signed(o_back_x) >= -18'sd65536))
        else $error("normalized entry outside unit range");

    a_zero_back : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_back_x == 18'd0 && o_back_y == 18'd0 && o_back_z == 18'd0)
        |-> (o_side_x == 18'd0 && o_side_y == 18'd0 && o_side_z == 18'd0))
        else $error("side row nonzero with a zero back row");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/lav_isqrt.sv =====
// Pipelined integer square root, one root bit per stage.
// Depends on lav_pkg for the stage count.
`default_nettype none
module lav_isqrt
    import lav_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic [61:0] i_n,
    output logic      [30:0] o_root
);

    logic [61:0] r_rem  [SQRT_STEPS];
    logic [30:0] r_root [SQRT_STEPS];

    for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_stage
        localparam int K = SQRT_STEPS - 1 - s;
        logic [63:0] rem_in;
        logic [63:0] term;
        logic [30:0] root_in;

        if (s == 0) begin : g_first
            assign rem_in  = {2'b00, i_n};
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = {2'b00, r_rem[s-1]};
            assign root_in = r_root[s-1];
        end

        // (2*root + 2^k) * 2^k is what setting bit k adds to root squared
        assign term = ({32'd0, root_in, 1'b0} | (64'd1 << K)) << K;

        always_ff @(posedge i_clk) begin
            if (rem_in >= term) begin
                r_rem[s]  <= 62'(rem_in - term);
                r_root[s] <= root_in | (31'd1 << K);
            end else begin
                r_rem[s]  <= rem_in[61:0];
                r_root[s] <= root_in;
            end
        end
    end

    assign o_root = r_root[SQRT_STEPS-1];

endmodule
`default_nettype wire

// ===== rtl/core/lav_div.sv =====
// Pipelined restoring divider: rounded (mag * 2^30) / root, one bit per stage.
// Depends on lav_pkg for the stage count.
`default_nettype none
module lav_div
    import lav_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic [29:0] i_mag,
    input  wire logic [30:0] i_root,
    output logic      [30:0] o_quot
);

    logic [60:0] r_d;
    logic [30:0] r_r;
    logic [31:0] r_p  [DIV_STEPS];
    logic [60:0] r_dd [DIV_STEPS];
    logic [30:0] r_rr [DIV_STEPS];
    logic [30:0] r_q  [DIV_STEPS];

    // add half the divisor so the quotient rounds to nearest
    always_ff @(posedge i_clk) begin
        r_d <= 61'({i_mag, 30'd0}) + 61'(i_root[30:1]);
        r_r <= i_root;
    end

    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_stage
        localparam int J = DIV_STEPS - 1 - s;
        logic [31:0] p_in;
        logic [60:0] d_in;
        logic [30:0] rr_in;
        logic [30:0] q_in;
        logic [31:0] trial;

        if (s == 0) begin : g_first
            assign p_in  = 32'(r_d[60:31]);
            assign d_in  = r_d;
            assign rr_in = r_r;
            assign q_in  = '0;
        end else begin : g_next
            assign p_in  = r_p[s-1];
            assign d_in  = r_dd[s-1];
            assign rr_in = r_rr[s-1];
            assign q_in  = r_q[s-1];
        end

        assign trial = {p_in[30:0], d_in[J]};

        always_ff @(posedge i_clk) begin
            r_dd[s] <= d_in;
            r_rr[s] <= rr_in;
            if (trial >= {1'b0, rr_in}) begin
                r_p[s] <= trial - {1'b0, rr_in};
                r_q[s] <= q_in | (31'd1 << J);
            end else begin
                r_p[s] <= trial;
                r_q[s] <= q_in;
            end
        end
    end

    assign o_quot = r_q[DIV_STEPS-1];

endmodule
`default_nettype wire

// ===== rtl/core/lav_norm.sv =====
// Vector normalizer: block scaling, sum of squares, square root, divide to Q.30.
// Depends on lav_pkg, lav_isqrt and lav_div.
`default_nettype none
module lav_norm
    import lav_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    input  wire t_vec64 i_vec,
    output logic        o_valid,
    output t_vec32      o_vec
);

    localparam int FL_LEN = NORM_LAT - 3;

    typedef struct packed {
        logic       valid;
        logic       zero;
        logic [2:0] neg;
    } t_nflags;

    logic        r1_valid, r2_valid;
    logic [2:0]  r1_neg, r2_neg;
    logic [62:0] r1_mag [3];
    logic [62:0] r2_mag [3];
    logic [62:0] r3_mag [3];
    logic [62:0] r1_or;
    logic [7:0]  r2_nz;
    logic [2:0]  r2_pos [8];
    logic [5:0]  r3_p;
    logic [29:0] r4_mag [3];
    logic [29:0] r5_mag [3];
    logic [59:0] r5_sq  [3];
    logic [29:0] r6_mag [3];
    logic [61:0] r6_sum;
    logic [29:0] r_mg [SQRT_STEPS][3];
    t_nflags     r_fl [FL_LEN];
    t_vec32      r_out;
    logic        r_out_valid;

    logic [62:0] n_mag [3];
    logic [2:0]  n_neg;
    logic [63:0] grp_word;
    logic [7:0]  n_nz;
    logic [2:0]  n_pos [8];
    logic [5:0]  n_p;
    logic [29:0] n_mag30 [3];
    logic [5:0]  rsh, lsh;
    logic [62:0] shifted [3];
    logic [30:0] root;
    logic [30:0] quot [3];

    // stage 1: sign and magnitude
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_neg[i] = i_vec[i][63];
            n_mag[i] = n_neg[i] ? 63'(-$signed(i_vec[i])) : i_vec[i][62:0];
        end
    end

    // stage 2: leading-one search per byte
    assign grp_word = {1'b0, r1_or};
    always_comb begin
        for (int g = 0; g < 8; g++) begin
            n_nz[g]  = |grp_word[g*8 +: 8];
            n_pos[g] = '0;
            for (int b = 0; b < 8; b++) begin
                if (grp_word[g*8 + b]) n_pos[g] = 3'(b);
            end
        end
    end

    // stage 3: combine bytes into the top bit position
    always_comb begin
        n_p = '0;
        for (int g = 0; g < 8; g++) begin
            if (r2_nz[g]) n_p = {3'(g), r2_pos[g]};
        end
    end

    // stage 4: move the top bit to position 29
    assign rsh = r3_p - 6'd29;
    assign lsh = 6'd29 - r3_p;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            shifted[i] = (r3_p >= 6'd29) ? (r3_mag[i] >> rsh) : (r3_mag[i] << lsh);
            n_mag30[i] = shifted[i][29:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r1_or    <= n_mag[0] | n_mag[1] | n_mag[2];
        r1_neg   <= n_neg;
        r2_nz    <= n_nz;
        r2_neg   <= r1_neg;
        r3_p     <= n_p;
        r6_sum   <= 62'(r5_sq[0]) + 62'(r5_sq[1]) + 62'(r5_sq[2]);
        for (int i = 0; i < 3; i++) begin
            r1_mag[i] <= n_mag[i];
            r2_mag[i] <= r1_mag[i];
            r3_mag[i] <= r2_mag[i];
            r4_mag[i] <= n_mag30[i];
            r5_mag[i] <= r4_mag[i];
            r5_sq[i]  <= r4_mag[i] * r4_mag[i];
            r6_mag[i] <= r5_mag[i];
            r_mg[0][i] <= r6_mag[i];
        end
        for (int g = 0; g < 8; g++) begin
            r2_pos[g] <= n_pos[g];
        end
        for (int k = 1; k < SQRT_STEPS; k++) begin
            r_mg[k] <= r_mg[k-1];
        end
    end

    // flags follow the data from stage 3 to the output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < FL_LEN; k++) begin
                r_fl[k] <= '0;
            end
        end else begin
            r1_valid    <= i_valid;
            r2_valid    <= r1_valid;
            r_fl[0]     <= '{valid: r2_valid, zero: ~|r2_nz, neg: r2_neg};
            for (int k = 1; k < FL_LEN; k++) begin
                r_fl[k] <= r_fl[k-1];
            end
            r_out_valid <= r_fl[FL_LEN-1].valid;
        end
    end

    lav_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_n    (r6_sum),
        .o_root (root)
    );

    for (genvar i = 0; i < 3; i++) begin : g_lane
        lav_div u_div (
            .i_clk  (i_clk),
            .i_mag  (r_mg[SQRT_STEPS-1][i]),
            .i_root (root),
            .o_quot (quot[i])
        );
    end

    // drop the result of a zero vector, put the sign back
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            if (r_fl[FL_LEN-1].zero) begin
                r_out[i] <= '0;
            end else if (r_fl[FL_LEN-1].neg[i]) begin
                r_out[i] <= -$signed({1'b0, quot[i]});
            end else begin
                r_out[i] <= {1'b0, quot[i]};
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_vec   = r_out;

endmodule
`default_nettype wire

// ===== rtl/core/lav_cross.sv =====
// Two-stage cross product a x b: products, then differences.
// Depends on lav_pkg for the vector types.
`default_nettype none
module lav_cross
    import lav_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    input  wire t_vec32 i_a,
    input  wire t_vec32 i_b,
    output logic        o_valid,
    output t_vec64      o_c
);

    logic signed [31:0] a [3];
    logic signed [31:0] b [3];
    logic signed [63:0] r_p [6];
    t_vec64             r_c;
    logic               r_v1, r_v2;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            a[i] = i_a[i];
            b[i] = i_b[i];
        end
    end

    always_ff @(posedge i_clk) begin
        r_p[0] <= a[1] * b[2];
        r_p[1] <= a[2] * b[1];
        r_p[2] <= a[2] * b[0];
        r_p[3] <= a[0] * b[2];
        r_p[4] <= a[0] * b[1];
        r_p[5] <= a[1] * b[0];
        r_c[0] <= r_p[0] - r_p[1];
        r_c[1] <= r_p[2] - r_p[3];
        r_c[2] <= r_p[4] - r_p[5];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    assign o_valid = r_v2;
    assign o_c     = r_c;

endmodule
`default_nettype wire

// ===== test/look_at_view_rotation_tb.sv =====
// Testbench for the look-at view rotation block: directed and random camera words,
// checked against a fixed-point predictor of the three normalized rows.
// Depends on lav_pkg and look_at_view_rotation.
`timescale 1ns / 1ps
`default_nettype none
module look_at_view_rotation_tb;
    import lav_pkg::*;

    typedef struct packed {
        logic [31:0] eye_x, eye_y, eye_z;
        logic [31:0] tgt_x, tgt_y, tgt_z;
        logic [31:0] up_x, up_y, up_z;
    } t_camera;

    typedef struct packed {
        logic [17:0] side_x, side_y, side_z;
        logic [17:0] upright_x, upright_y, upright_z;
        logic [17:0] back_x, back_y, back_z;
    } t_rows;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_camera     cam = '0;
    logic        o_valid;
    wire t_rows  got;

    t_rows       rows_pending[$];
    int          error_count = 0;
    int          send_idle_pct = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    look_at_view_rotation DUT (
        .i_clk, .i_rst_n, .start, .busy,
        .i_eye_x(cam.eye_x), .i_eye_y(cam.eye_y), .i_eye_z(cam.eye_z),
        .i_target_x(cam.tgt_x), .i_target_y(cam.tgt_y), .i_target_z(cam.tgt_z),
        .i_up_x(cam.up_x), .i_up_y(cam.up_y), .i_up_z(cam.up_z),
        .o_valid,
        .o_side_x(got.side_x), .o_side_y(got.side_y), .o_side_z(got.side_z),
        .o_upright_x(got.upright_x), .o_upright_y(got.upright_y),
        .o_upright_z(got.upright_z),
        .o_back_x(got.back_x), .o_back_y(got.back_y), .o_back_z(got.back_z)
    );

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] root;
        logic [63:0] bitv;
        root = '0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // scale to unit length in Q.30; a zero vector stays zero
    function automatic t_vec64 unit_q30(t_vec64 v);
        logic [63:0] mag[3];
        logic        neg[3];
        logic [63:0] top, sum, r, q;
        top = '0;
        sum = '0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = v[i][63];
            mag[i] = neg[i] ? -v[i] : v[i];
            if (mag[i] > top) top = mag[i];
        end
        if (top == 0) return v;
        while (top >= (64'd1 << 30)) begin
            top = top >> 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
        end
        while (top < (64'd1 << 29)) begin
            top = top << 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
        end
        for (int i = 0; i < 3; i++) sum = sum + mag[i] * mag[i];
        r = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << 30) + (r >> 1)) / r;
            v[i] = neg[i] ? -q : q;
        end
        return v;
    endfunction

    function automatic logic [17:0] q30_to_q16(t_s64 c);
        logic [63:0] m;
        t_s64        q;
        m = c < 0 ? -c : c;
        m = (m + (64'd1 << 13)) >> 14;
        q = c < 0 ? -t_s64'(m) : t_s64'(m);
        if (q > 131071) q = 131071;
        if (q < -131072) q = -131072;
        return q[17:0];
    endfunction

    function automatic t_rows view_rows(t_camera c);
        t_vec64 z, x, y, up;
        t_rows  res;
        z[0] = t_s64'($signed(c.eye_x)) - t_s64'($signed(c.tgt_x));
        z[1] = t_s64'($signed(c.eye_y)) - t_s64'($signed(c.tgt_y));
        z[2] = t_s64'($signed(c.eye_z)) - t_s64'($signed(c.tgt_z));
        up[0] = t_s64'($signed(c.up_x));
        up[1] = t_s64'($signed(c.up_y));
        up[2] = t_s64'($signed(c.up_z));
        z = unit_q30(z);
        x[0] = up[1] * z[2] - up[2] * z[1];
        x[1] = up[2] * z[0] - up[0] * z[2];
        x[2] = up[0] * z[1] - up[1] * z[0];
        x = unit_q30(x);
        y[0] = z[1] * x[2] - z[2] * x[1];
        y[1] = z[2] * x[0] - z[0] * x[2];
        y[2] = z[0] * x[1] - z[1] * x[0];
        y = unit_q30(y);
        res.side_x = q30_to_q16(x[0]);
        res.side_y = q30_to_q16(x[1]);
        res.side_z = q30_to_q16(x[2]);
        res.upright_x = q30_to_q16(y[0]);
        res.upright_y = q30_to_q16(y[1]);
        res.upright_z = q30_to_q16(y[2]);
        res.back_x = q30_to_q16(z[0]);
        res.back_y = q30_to_q16(z[1]);
        res.back_z = q30_to_q16(z[2]);
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [17:0] seen, logic [17:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what,
                 $signed(seen), $signed(want), $realtime);
        error_count++;
    endtask

    // send one word; random idle cycles ahead of it
    task automatic send_camera(t_camera c);
        while ($urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        cam <= c;
        start <= 1'b1;
        rows_pending.push_back(view_rows(c));
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_rows want;
        if (i_rst_n && o_valid) begin
            if (rows_pending.size() == 0) begin
                $display("unexpected result word at %0t", $realtime);
                error_count++;
            end else begin
                want = rows_pending.pop_front();
                if (got.side_x !== want.side_x) report_mismatch("side_x", got.side_x, want.side_x);
                if (got.side_y !== want.side_y) report_mismatch("side_y", got.side_y, want.side_y);
                if (got.side_z !== want.side_z) report_mismatch("side_z", got.side_z, want.side_z);
                if (got.upright_x !== want.upright_x)
                    report_mismatch("upright_x", got.upright_x, want.upright_x);
                if (got.upright_y !== want.upright_y)
                    report_mismatch("upright_y", got.upright_y, want.upright_y);
                if (got.upright_z !== want.upright_z)
                    report_mismatch("upright_z", got.upright_z, want.upright_z);
                if (got.back_x !== want.back_x) report_mismatch("back_x", got.back_x, want.back_x);
                if (got.back_y !== want.back_y) report_mismatch("back_y", got.back_y, want.back_y);
                if (got.back_z !== want.back_z) report_mismatch("back_z", got.back_z, want.back_z);
            end
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(4))
            0: return $urandom();
            1: return 32'($signed($urandom_range(1 << 21)) - (1 << 20));
            2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(1 << 25)) - (1 << 24));
        endcase
    endfunction

    function automatic t_camera rand_camera();
        t_camera c;
        c = {rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
             rand_coord(), rand_coord(), rand_coord(), rand_coord()};
        case ($urandom_range(9))
            0: c.tgt_x = c.eye_x; // flatten one axis of the back vector
            1: {c.tgt_x, c.tgt_y, c.tgt_z} = {c.eye_x, c.eye_y, c.eye_z};
            2: {c.up_x, c.up_y, c.up_z} = '0;
            3: begin // up parallel to the back vector
                c.up_x = 32'($signed(c.eye_x) - $signed(c.tgt_x));
                c.up_y = 32'($signed(c.eye_y) - $signed(c.tgt_y));
                c.up_z = 32'($signed(c.eye_z) - $signed(c.tgt_z));
            end
            default: ;
        endcase
        return c;
    endfunction

    task automatic wait_drained();
        start <= 1'b0;
        while (rows_pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        localparam logic [31:0] ONE = 32'h0001_0000;
        localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
        localparam logic [31:0] MINV = 32'h8000_0000;
        send_camera('{ONE, 0, 0, 0, 0, 0, 0, ONE, 0});
        send_camera('{0, 0, ONE, 0, 0, 0, 0, ONE, 0});
        send_camera('{0, 0, 0, 0, 0, 0, 0, ONE, 0});          // eye equals target
        send_camera('{0, 0, ONE, 0, 0, 0, 0, 0, 0});          // zero up
        send_camera('{0, ONE, 0, 0, 0, 0, 0, ONE, 0});        // up parallel
        send_camera('{MAXV, MAXV, MAXV, MINV, MINV, MINV, MAXV, MAXV, MAXV});
        send_camera('{MINV, MINV, MINV, MAXV, MAXV, MAXV, MINV, MINV, MINV});
        send_camera('{MAXV, MINV, MAXV, MINV, MAXV, MINV, MINV, MAXV, MINV});
        send_camera('{1, 0, 0, 0, 0, 0, 0, 0, 1});            // tiny vectors
        send_camera('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 1, 0, 0});
        send_camera('{MAXV, 0, 0, MINV, 0, 0, 0, MINV, 0});
        send_camera('{ONE, ONE, ONE, 0, 0, 0, 0, ONE, 0});
        send_camera('{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV});
        send_camera('{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                      32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                      32'h5555_5555});
        send_camera('{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                      32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                      32'hAAAA_AAAA});
        send_camera('{0, 0, 0, 0, 0, MINV, MINV, 0, 0});
    endtask

    task automatic test_random(int count, int idle_pct);
        send_idle_pct = idle_pct;
        repeat (count) send_camera(rand_camera());
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        wait_drained();           // hold off until the pipe is empty
        test_random(400, 17);
        test_random(400, 80);
        test_random(400, 0);
        wait_drained();
        repeat (TOTAL_LAT + 20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("timeout");
        $display("*** FAILED ***");
        $finish;
    end

endmodule
`default_nettype wire
